### hw/rtl/crcdt_pkg.sv
`timescale 1ns / 1ps
// Package for the CRC-16 decimal trailer core: beat types, codes and helpers.
// No dependencies.
package crcdt_pkg;

   localparam int unsigned TRAILER_DIGITS = 5;
   localparam int unsigned DIGIT_CNT_W    = 3;
   localparam int unsigned CSR_INDEX_W    = 1;
   localparam int unsigned CSR_DATA_W     = 16;
   localparam int unsigned DEC_W          = 17;

   localparam logic [15:0] CRC_POLY = 16'hA001;
   localparam logic [7:0]  ASCII_ZERO = 8'h30;
   localparam logic [7:0]  ASCII_NINE = 8'h39;

   localparam logic [CSR_INDEX_W-1:0] CSR_MODE = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SEED = 1'b1;

   localparam logic MODE_GENERATE = 1'b0;
   localparam logic MODE_CHECK    = 1'b1;

   localparam logic [1:0] VERDICT_OK       = 2'd0;
   localparam logic [1:0] VERDICT_MISMATCH = 2'd1;
   localparam logic [1:0] VERDICT_SHORT    = 2'd2;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       in_last;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_valid;
      logic       out_last;
      logic [1:0] verdict;
   } rsp_payload_type;

   function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] data);
      logic [15:0] t;
      int          i;
      t = {8'h00, crc[7:0] ^ data};
      for (i = 0; i < 8; i++) begin
         t = t[0] ? ((t >> 1) ^ CRC_POLY) : (t >> 1);
      end
      return {8'h00, crc[15:8]} ^ t;
   endfunction

   // weight of a digit position, most significant digit at position 0
   function automatic logic [DEC_W-1:0] dec_weight(input logic [DIGIT_CNT_W-1:0] pos);
      logic [DEC_W-1:0] w;
      case (pos)
         3'd0: begin
            w = 17'd10000;
         end
         3'd1: begin
            w = 17'd1000;
         end
         3'd2: begin
            w = 17'd100;
         end
         3'd3: begin
            w = 17'd10;
         end
         default: begin
            w = 17'd1;
         end
      endcase
      return w;
   endfunction

endpackage

### hw/rtl/crc16_decimal_trailer_core.sv
`timescale 1ns / 1ps
// CRC-16 (reflected 0xA001) over a byte stream with a five-digit ASCII decimal
// trailer: appended in generate mode, checked and stripped in check mode.
// Depends on crcdt_pkg.
// The result of an accepted beat is in the output register in the next cycle.
// Throughput while the output is not stalled: one beat per cycle; the last beat of a
// generate-mode message stalls the input while the digit unit emits one digit per cycle.
// Check mode gives no result for a message's first five beats, save a too-short verdict.
// Reset: synchronous; mode 0, seed 0, no message open, output empty.
module crc16_decimal_trailer_core (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  crcdt_pkg::req_payload_type           req_payload,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output crcdt_pkg::rsp_payload_type           rsp_payload,
   input  logic                                 csr_write_en,
   input  logic [crcdt_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [crcdt_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import crcdt_pkg::*;

   logic                   mode_ff, mode_in;
   logic [15:0]            seed_ff, seed_in;
   logic                   msg_open_ff, msg_open_in;
   logic [DIGIT_CNT_W-1:0] fill_ff, fill_in;
   logic [DIGIT_CNT_W-1:0] dig_cnt_ff, dig_cnt_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [15:0]            crc_acc_ff, crc_acc_in;
   logic [15:0]            rem_ff, rem_in;
   logic [7:0]             delay_ff [TRAILER_DIGITS];
   logic [7:0]             delay_in [TRAILER_DIGITS];
   rsp_payload_type        rsp_payload_ff, rsp_payload_in;

   logic                   out_free;
   logic                   req_accept;
   logic                   dig_fire;
   logic                   full;
   logic [15:0]            crc_base;
   logic [7:0]             crc_data;
   logic [15:0]            crc_new;
   logic [DIGIT_CNT_W-1:0] dig_pos;
   logic [DEC_W-1:0]       dig_w;
   logic [3:0]             dig_val;
   logic [DEC_W-1:0]       dig_sub;
   logic [7:0]             trailer [TRAILER_DIGITS];
   logic [DEC_W-1:0]       trailer_val;
   logic                   trailer_ok;
   logic [7:0]             t_off;

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign req_stall  = (dig_cnt_ff != '0) || !out_free;
   assign req_accept = req_valid && !req_stall;
   assign dig_fire   = (dig_cnt_ff != '0) && out_free;
   assign full       = (fill_ff == DIGIT_CNT_W'(TRAILER_DIGITS));
   assign crc_base   = msg_open_ff ? crc_acc_ff : seed_ff;
   assign crc_data   = (mode_ff == MODE_CHECK) ? delay_ff[0] : req_payload.in_byte;
   assign crc_new    = crc16_step(crc_base, crc_data);
   assign dig_pos    = DIGIT_CNT_W'(TRAILER_DIGITS) - dig_cnt_ff;
   assign dig_w      = dec_weight(dig_pos);

   // next digit of the remainder: count the multiples of the weight that fit
   always_comb begin
      int k;
      dig_val = '0;
      dig_sub = '0;
      for (k = 1; k < 10; k++) begin
         if (DEC_W'(4'(k) * dig_w) <= {1'b0, rem_ff}) begin
            dig_val = 4'(k);
            dig_sub = DEC_W'(4'(k) * dig_w);
         end
      end
   end

   // trailer as held after this beat, most significant digit first
   always_comb begin
      int i;
      for (i = 0; i < TRAILER_DIGITS - 1; i++) begin
         trailer[i] = delay_ff[i + 1];
      end
      trailer[TRAILER_DIGITS - 1] = req_payload.in_byte;
      trailer_val = '0;
      trailer_ok  = 1'b1;
      t_off       = '0;
      for (i = 0; i < TRAILER_DIGITS; i++) begin
         if (trailer[i] < ASCII_ZERO || trailer[i] > ASCII_NINE) begin
            trailer_ok = 1'b0;
         end
         t_off       = trailer[i] - ASCII_ZERO;
         trailer_val = trailer_val + DEC_W'(t_off[3:0] * dec_weight(DIGIT_CNT_W'(i)));
      end
   end

   always_comb begin
      int i;
      mode_in        = mode_ff;
      seed_in        = seed_ff;
      msg_open_in    = msg_open_ff;
      fill_in        = fill_ff;
      dig_cnt_in     = dig_cnt_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      crc_acc_in     = crc_acc_ff;
      rem_in         = rem_ff;
      delay_in       = delay_ff;
      rsp_payload_in = rsp_payload_ff;

      if (dig_fire) begin
         rsp_valid_in              = 1'b1;
         rsp_payload_in.out_byte   = ASCII_ZERO + {4'h0, dig_val};
         rsp_payload_in.byte_valid = 1'b1;
         rsp_payload_in.out_last   = (dig_cnt_ff == DIGIT_CNT_W'(1));
         rsp_payload_in.verdict    = VERDICT_OK;
         rem_in                    = rem_ff - dig_sub[15:0];
         dig_cnt_in                = dig_cnt_ff - DIGIT_CNT_W'(1);
      end

      if (req_accept) begin
         msg_open_in = !req_payload.in_last;
         if (mode_ff == MODE_GENERATE) begin
            crc_acc_in                = crc_new;
            rsp_valid_in              = 1'b1;
            rsp_payload_in.out_byte   = req_payload.in_byte;
            rsp_payload_in.byte_valid = 1'b1;
            rsp_payload_in.out_last   = 1'b0;
            rsp_payload_in.verdict    = VERDICT_OK;
            if (req_payload.in_last) begin
               rem_in     = crc_new;
               dig_cnt_in = DIGIT_CNT_W'(TRAILER_DIGITS);
            end
         end else begin
            for (i = 0; i < TRAILER_DIGITS - 1; i++) begin
               delay_in[i] = delay_ff[i + 1];
            end
            delay_in[TRAILER_DIGITS - 1] = req_payload.in_byte;
            if (!full) begin
               crc_acc_in = crc_base;
               fill_in    = fill_ff + DIGIT_CNT_W'(1);
               if (req_payload.in_last) begin
                  rsp_valid_in              = 1'b1;
                  rsp_payload_in.out_byte   = '0;
                  rsp_payload_in.byte_valid = 1'b0;
                  rsp_payload_in.out_last   = 1'b1;
                  rsp_payload_in.verdict    = VERDICT_SHORT;
               end
            end else begin
               crc_acc_in                = crc_new;
               rsp_valid_in              = 1'b1;
               rsp_payload_in.out_byte   = delay_ff[0];
               rsp_payload_in.byte_valid = 1'b1;
               rsp_payload_in.out_last   = req_payload.in_last;
               rsp_payload_in.verdict    = VERDICT_OK;
               if (req_payload.in_last && !(trailer_ok && trailer_val == {1'b0, crc_new})) begin
                  rsp_payload_in.verdict = VERDICT_MISMATCH;
               end
            end
            if (req_payload.in_last) begin
               fill_in = '0;
            end
         end
      end

      if (csr_write_en) begin
         case (csr_index)
            CSR_MODE: begin
               mode_in     = csr_wdata[0];
               msg_open_in = 1'b0;
               fill_in     = '0;
            end
            CSR_SEED: begin
               seed_in = csr_wdata[15:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_GENERATE;
         seed_ff      <= '0;
         msg_open_ff  <= 1'b0;
         fill_ff      <= '0;
         dig_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mode_ff      <= mode_in;
         seed_ff      <= seed_in;
         msg_open_ff  <= msg_open_in;
         fill_ff      <= fill_in;
         dig_cnt_ff   <= dig_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      crc_acc_ff     <= crc_acc_in;
      rem_ff         <= rem_in;
      delay_ff       <= delay_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   a_no_accept_while_digits : assert property (@(posedge clock) disable iff (reset)
      (dig_cnt_ff != '0) |-> !req_accept)
      else $error("beat accepted while trailer digits pending");

   a_digits_start : assert property (@(posedge clock) disable iff (reset)
      (req_accept && mode_ff == MODE_GENERATE && req_payload.in_last)
      |=> (dig_cnt_ff == DIGIT_CNT_W'(TRAILER_DIGITS)))
      else $error("trailer digit count not loaded");

   a_fill_range : assert property (@(posedge clock) disable iff (reset)
      (fill_ff <= DIGIT_CNT_W'(TRAILER_DIGITS)) && (dig_cnt_ff <= DIGIT_CNT_W'(TRAILER_DIGITS)))
      else $error("fill or digit count out of range");

   a_empty_beat_is_short : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_payload_ff.byte_valid)
      |-> (rsp_payload_ff.out_last && rsp_payload_ff.verdict == VERDICT_SHORT))
      else $error("beat without byte is not a too-short verdict");

endmodule
